// ===== rtl/tcwr_pkg.sv =====
// Shared constants and types for the three-channel windowed RMS meter.
package tcwr_pkg;

    // Channel and sample geometry.
    localparam int CHANNELS   = 3;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_BITS = 16;

    // Accumulator and arithmetic widths.
    localparam int SQUARE_W   = 2 * SAMPLE_W;
    localparam int SUM_W      = 46;
    localparam int FRAC_BITS  = 16;
    localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
    localparam int ROOT_W     = DIVIDEND_W / 2;
    localparam int TRIAL_W    = DIVIDEND_W + 1;
    localparam int GAIN_W     = 20;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int RMS_SHIFT  = 8;
    localparam int RMS_W      = 35;

    // Time keeping.
    localparam int MS_W  = 32;
    localparam int WIN_W = 16;

    // Configuration port.
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MICRO = 2'd1;
    localparam logic [WIN_W-1:0]     WINDOW_RESET   = 16'd1000;
    localparam logic [GAIN_W-1:0]    GAIN_RESET     = 20'd3125;

    // Input item kinds.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Depth of the queue of closed windows.
    localparam int JQ_DEPTH = 2;

    typedef logic [SUM_W-1:0] sum_t;

    // One closed window waiting for its RMS computation.
    typedef struct packed {
        logic [MS_W-1:0]       start_ms;
        logic [COUNT_BITS-1:0] count;
        sum_t [CHANNELS-1:0]   sums;
    } job_t;

    // One finished result transaction.
    typedef struct packed {
        logic [MS_W-1:0]                 start_ms;
        logic [COUNT_BITS-1:0]           count;
        logic [CHANNELS-1:0][RMS_W-1:0]  rms;
    } result_t;

    // Handshake between a producer and a queue of windows.
    typedef struct packed {
        logic push;
        logic pop;
    } jq_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jq_stat_t;

endpackage

// ===== rtl/tcwr_front.sv =====
// Front end: accepts samples and ticks, accumulates squares and closes windows.
module tcwr_front (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  push,
    output logic                                                  full,
    input  logic                                                  mode,
    input  logic [tcwr_pkg::CHANNELS-1:0][tcwr_pkg::SAMPLE_W-1:0] samples,
    input  logic [tcwr_pkg::WIN_W-1:0]                            window_ms,
    input  logic                                                  jq_full,
    output logic                                                  jq_push,
    output tcwr_pkg::job_t                                        jq_data
);

    localparam logic [tcwr_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    tcwr_pkg::sum_t [tcwr_pkg::CHANNELS-1:0]  sums_reg, sums_next;
    logic [tcwr_pkg::COUNT_BITS-1:0]          count_reg, count_next;
    logic [tcwr_pkg::WIN_W-1:0]               elapsed_reg, elapsed_next;
    logic [tcwr_pkg::MS_W-1:0]                clock_reg, clock_next;
    logic [tcwr_pkg::MS_W-1:0]                start_reg, start_next;

    logic [tcwr_pkg::CHANNELS-1:0][tcwr_pkg::SQUARE_W-1:0] square;
    logic [tcwr_pkg::WIN_W-1:0] limit;
    logic [tcwr_pkg::WIN_W-1:0] elapsed_inc;
    logic [tcwr_pkg::MS_W-1:0]  clock_inc;
    logic                       accept;

    // A closing tick needs a free queue slot, so the whole input stalls on a full queue.
    assign full   = jq_full;
    assign accept = push && !jq_full;

    // Squares of the signed samples, one multiplier per channel.
    always_comb
    begin
        for (int ch = 0; ch < tcwr_pkg::CHANNELS; ch++)
        begin
            square[ch] = $unsigned(tcwr_pkg::SQUARE_W'($signed(samples[ch]))
                                   * tcwr_pkg::SQUARE_W'($signed(samples[ch])));
        end
    end

    assign limit       = (window_ms == '0) ? tcwr_pkg::WIN_W'(1) : window_ms;
    assign elapsed_inc = elapsed_reg + tcwr_pkg::WIN_W'(1);
    assign clock_inc   = clock_reg + tcwr_pkg::MS_W'(1);

    // The queue entry is the window as it stands before the closing tick.
    assign jq_data.start_ms = start_reg;
    assign jq_data.count    = count_reg;
    assign jq_data.sums     = sums_reg;

    // Window bookkeeping for sample and tick transactions.
    always_comb
    begin
        sums_next    = sums_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        clock_next   = clock_reg;
        start_next   = start_reg;
        jq_push      = 1'b0;
        if (accept)
        begin
            if (mode == tcwr_pkg::MODE_SAMPLE)
            begin
                // A saturated count ignores further triples.
                if (count_reg != COUNT_MAX)
                begin
                    for (int ch = 0; ch < tcwr_pkg::CHANNELS; ch++)
                    begin
                        sums_next[ch] = sums_reg[ch] + tcwr_pkg::SUM_W'(square[ch]);
                    end
                    count_next = count_reg + tcwr_pkg::COUNT_BITS'(1);
                end
            end
            else
            begin
                clock_next = clock_inc;
                if (elapsed_inc >= limit)
                begin
                    jq_push      = 1'b1;
                    sums_next    = '0;
                    count_next   = '0;
                    elapsed_next = '0;
                    start_next   = clock_inc;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg    <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
            clock_reg   <= '0;
            start_reg   <= '0;
        end
        else
        begin
            sums_reg    <= sums_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            clock_reg   <= clock_next;
            start_reg   <= start_next;
        end
    end

endmodule

// ===== rtl/tcwr_jobq.sv =====
// Short queue of closed windows between the front end and the back end.
module tcwr_jobq (
    input  logic               clk,
    input  logic               rst_n,
    input  tcwr_pkg::jq_ctrl_t ctrl,
    output tcwr_pkg::jq_stat_t stat,
    input  tcwr_pkg::job_t     wr_data,
    output tcwr_pkg::job_t     rd_data
);

    localparam int AW = (tcwr_pkg::JQ_DEPTH > 1) ? $clog2(tcwr_pkg::JQ_DEPTH) : 1;
    localparam int FW = $clog2(tcwr_pkg::JQ_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(tcwr_pkg::JQ_DEPTH);
    localparam logic [AW-1:0] PTR_LAST  = AW'(tcwr_pkg::JQ_DEPTH - 1);

    tcwr_pkg::job_t  mem_reg [tcwr_pkg::JQ_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [FW-1:0]   fill_reg;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (fill_reg == FILL_MAX);
    assign stat.empty = (fill_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

// ===== rtl/tcwr_back.sv =====
// Back end: divides, takes square roots and scales each channel, then holds the result.
module tcwr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        jq_empty,
    input  tcwr_pkg::job_t              jq_data,
    output logic                        jq_pop,
    input  logic [tcwr_pkg::GAIN_W-1:0] gain_micro,
    input  logic                        pop,
    output logic                        empty,
    output tcwr_pkg::result_t           result
);

    localparam int STEP_W = $clog2(tcwr_pkg::DIVIDEND_W);
    localparam logic [STEP_W-1:0]            DIV_LAST = STEP_W'(tcwr_pkg::DIVIDEND_W - 1);
    localparam logic [tcwr_pkg::CH_W-1:0]    CH_LAST  = tcwr_pkg::CH_W'(tcwr_pkg::CHANNELS - 1);
    localparam logic [tcwr_pkg::TRIAL_W-1:0] BIT_TOP  =
        tcwr_pkg::TRIAL_W'(1) << (2 * tcwr_pkg::ROOT_W);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                                               state_reg;
    tcwr_pkg::job_t                                       job_reg;
    logic [tcwr_pkg::CH_W-1:0]                            ch_reg;
    logic [STEP_W-1:0]                                    step_reg;
    logic [tcwr_pkg::COUNT_BITS-1:0]                      rem_reg;
    logic [tcwr_pkg::DIVIDEND_W-1:0]                      dq_reg;
    logic [tcwr_pkg::DIVIDEND_W-1:0]                      v_reg;
    logic [tcwr_pkg::TRIAL_W-1:0]                         root_reg;
    logic [tcwr_pkg::TRIAL_W-1:0]                         bit_reg;
    logic [tcwr_pkg::PROD_W-1:0]                          prod_reg;
    logic [tcwr_pkg::CHANNELS-1:0][tcwr_pkg::RMS_W-1:0]   rms_reg;
    tcwr_pkg::result_t                                    res_reg;
    logic                                                 out_valid_reg;

    logic [tcwr_pkg::COUNT_BITS:0]   div_trial;
    logic [tcwr_pkg::COUNT_BITS:0]   div_diff;
    logic                            div_ge;
    logic [tcwr_pkg::DIVIDEND_W-1:0] dq_next;
    logic [tcwr_pkg::TRIAL_W-1:0]    sq_trial;
    logic                            sq_ge;
    logic                            out_taken;
    logic                            can_load;

    assign jq_pop    = (state_reg == S_IDLE) && !jq_empty;
    assign empty     = !out_valid_reg;
    assign result    = res_reg;
    assign out_taken = pop && out_valid_reg;
    assign can_load  = !out_valid_reg || out_taken;

    // One restoring division step: remainder against the sample count.
    assign div_trial = {rem_reg, dq_reg[tcwr_pkg::DIVIDEND_W-1]};
    assign div_ge    = (div_trial >= {1'b0, job_reg.count});
    assign div_diff  = div_trial - {1'b0, job_reg.count};
    assign dq_next   = {dq_reg[tcwr_pkg::DIVIDEND_W-2:0], div_ge};

    // One digit-by-digit square root step.
    assign sq_trial = root_reg + bit_reg;
    assign sq_ge    = ({1'b0, v_reg} >= sq_trial);

    // Sequencer over the channels of one window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!jq_empty)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    step_reg  <= '0;
                    state_reg <= (job_reg.count == '0) ? S_STORE : S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == DIV_LAST)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + tcwr_pkg::CH_W'(1);
                        state_reg <= S_SETUP;
                    end
                end
                S_DONE:
                begin
                    if (can_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!jq_empty)
                begin
                    job_reg <= jq_data;
                end
            end
            S_SETUP:
            begin
                // An empty window skips the multiply, so the cleared product gives it zero.
                prod_reg <= '0;
                rem_reg  <= '0;
                dq_reg   <= {job_reg.sums[ch_reg], tcwr_pkg::FRAC_BITS'(0)};
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? div_diff[tcwr_pkg::COUNT_BITS-1:0]
                                  : div_trial[tcwr_pkg::COUNT_BITS-1:0];
                dq_reg  <= dq_next;
                if (step_reg == DIV_LAST)
                begin
                    v_reg    <= dq_next;
                    root_reg <= '0;
                    bit_reg  <= BIT_TOP;
                end
            end
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg    <= v_reg - sq_trial[tcwr_pkg::DIVIDEND_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_MUL:
            begin
                prod_reg <= tcwr_pkg::PROD_W'(root_reg[tcwr_pkg::ROOT_W-1:0])
                            * tcwr_pkg::PROD_W'(gain_micro);
            end
            S_STORE:
            begin
                rms_reg[ch_reg] <= prod_reg[tcwr_pkg::RMS_SHIFT +: tcwr_pkg::RMS_W];
            end
            default:
            begin
            end
        endcase
    end

    // Result holding register toward the output side.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && can_load)
        begin
            res_reg.start_ms <= job_reg.start_ms;
            res_reg.count    <= job_reg.count;
            res_reg.rms      <= rms_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && can_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/three_channel_windowed_rms.sv =====
// Top level of the three-channel windowed RMS meter with its configuration registers.
//
// Sample and tick transactions are taken one per clock cycle while full is low; full
// rises only while both slots of the two-entry window queue hold closed windows. Each
// closed window is then worked off by one shared back end, per channel a setup step,
// bit-serial division, a digit-by-digit square root, a multiply and a store step; an
// empty window goes from setup straight to the store step. The result waits in an
// output register until popped while the next window is already being computed.
// Configuration writes take effect at once.
module three_channel_windowed_rms (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               mode,
    input  logic signed [15:0]                 sample_a,
    input  logic signed [15:0]                 sample_b,
    input  logic signed [15:0]                 sample_c,
    output logic                               empty,
    input  logic                               pop,
    output logic [31:0]                        window_start_ms,
    output logic [15:0]                        sample_count,
    output logic [34:0]                        rms_a,
    output logic [34:0]                        rms_b,
    output logic [34:0]                        rms_c,
    input  logic                               cfg_we,
    input  logic [tcwr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcwr_pkg::CFG_W-1:0]         cfg_data
);

    logic [tcwr_pkg::WIN_W-1:0]  window_reg;
    logic [tcwr_pkg::GAIN_W-1:0] gain_reg;

    logic [tcwr_pkg::CHANNELS-1:0][tcwr_pkg::SAMPLE_W-1:0] samples;
    tcwr_pkg::job_t     jq_wr_data;
    tcwr_pkg::job_t     jq_rd_data;
    tcwr_pkg::jq_ctrl_t jq_ctrl;
    tcwr_pkg::jq_stat_t jq_stat;
    tcwr_pkg::result_t  result;
    logic               jq_push;
    logic               jq_pop;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= tcwr_pkg::WINDOW_RESET;
            gain_reg   <= tcwr_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcwr_pkg::REG_WINDOW_MS:  window_reg <= cfg_data[tcwr_pkg::WIN_W-1:0];
                tcwr_pkg::REG_GAIN_MICRO: gain_reg   <= cfg_data[tcwr_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign samples[0] = sample_a;
    assign samples[1] = sample_b;
    assign samples[2] = sample_c;

    tcwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .samples   (samples),
        .window_ms (window_reg),
        .jq_full   (jq_stat.full),
        .jq_push   (jq_push),
        .jq_data   (jq_wr_data)
    );

    assign jq_ctrl.push = jq_push;
    assign jq_ctrl.pop  = jq_pop;

    tcwr_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (jq_ctrl),
        .stat    (jq_stat),
        .wr_data (jq_wr_data),
        .rd_data (jq_rd_data)
    );

    tcwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jq_empty   (jq_stat.empty),
        .jq_data    (jq_rd_data),
        .jq_pop     (jq_pop),
        .gain_micro (gain_reg),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    // Result transaction fields.
    assign window_start_ms = result.start_ms;
    assign sample_count    = result.count;
    assign rms_a           = result.rms[0];
    assign rms_b           = result.rms[1];
    assign rms_c           = result.rms[2];

    // A closed window is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) jq_push |-> !jq_stat.full)
        else $error("closed window pushed into a full window queue");

    // The back end only takes a window that is there.
    assert property (@(posedge clk) disable iff (!rst_n) jq_pop |-> !jq_stat.empty)
        else $error("back end popped an empty window queue");

    // An empty window reports zero in every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sample_count == 16'd0) |-> (rms_a == '0 && rms_b == '0 && rms_c == '0))
        else $error("empty window reported a nonzero RMS");

endmodule

// ===== sim/tb_three_channel_windowed_rms.sv =====
// Self-checking testbench for the three-channel windowed RMS meter.
module tb_three_channel_windowed_rms;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused register indexes on the configuration port.
    localparam logic [tcwr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [tcwr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int SETTLE_CYCLES  = 320;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_OFF_LEN   = 600;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 150;
    localparam logic [19:0] GAIN_MAX = 20'hFFFFF;

    // One closed window as the block should report it.
    typedef struct packed {
        logic [31:0] start_ms;
        logic [15:0] count;
        logic [34:0] rms_a;
        logic [34:0] rms_b;
        logic [34:0] rms_c;
    } window_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           mode = tcwr_pkg::MODE_TICK;
    logic signed [15:0]             sample_a = '0;
    logic signed [15:0]             sample_b = '0;
    logic signed [15:0]             sample_c = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [31:0]                    window_start_ms;
    logic [15:0]                    sample_count;
    logic [34:0]                    rms_a;
    logic [34:0]                    rms_b;
    logic [34:0]                    rms_c;
    logic                           cfg_we = 1'b0;
    logic [tcwr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tcwr_pkg::CFG_W-1:0]     cfg_data = '0;

    // Predicted meter state and register copies.
    logic [45:0] square_total [3];
    logic [15:0] triples_seen;
    logic [15:0] window_age;
    logic [31:0] ms_now;
    logic [31:0] window_began;
    logic [15:0] window_len;
    logic [19:0] gain_setting;

    window_report_t pending_reports[$];
    int mismatch_count = 0;
    int idle_pct = 14;
    int hold_off_cycles = 0;
    int stall_cycles = 0;

    three_channel_windowed_rms dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .sample_a        (sample_a),
        .sample_b        (sample_b),
        .sample_c        (sample_c),
        .empty           (empty),
        .pop             (pop),
        .window_start_ms (window_start_ms),
        .sample_count    (sample_count),
        .rms_a           (rms_a),
        .rms_b           (rms_b),
        .rms_c           (rms_c),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 clk = ~clk;

    // Integer square root, rounded down.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rest;
        root  = '0;
        rest  = v;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // RMS of one channel in microunits: root of the Q16 mean square, scaled by the gain.
    function automatic logic [34:0] channel_rms_micro(input logic [45:0] total,
                                                      input logic [15:0] cnt);
        logic [63:0] mean_q16;
        logic [63:0] scaled;
        if (cnt == 0)
            return '0;
        mean_q16 = (64'(total) << 16) / 64'(cnt);
        scaled   = (root_floor(mean_q16) * 64'(gain_setting)) >> 8;
        return scaled[34:0];
    endfunction

    // Advance the predicted state by one accepted transaction.
    function automatic void predict_item(input logic m, input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
        window_report_t rep;
        logic [15:0] limit;
        if (m == tcwr_pkg::MODE_SAMPLE)
        begin
            if (triples_seen == 16'hFFFF)
                return;
            square_total[0] += 46'(longint'(a) * longint'(a));
            square_total[1] += 46'(longint'(b) * longint'(b));
            square_total[2] += 46'(longint'(c) * longint'(c));
            triples_seen++;
            return;
        end
        ms_now++;
        window_age++;
        limit = (window_len == 0) ? 16'd1 : window_len;
        if (window_age < limit)
            return;
        rep.start_ms = window_began;
        rep.count    = triples_seen;
        rep.rms_a    = channel_rms_micro(square_total[0], triples_seen);
        rep.rms_b    = channel_rms_micro(square_total[1], triples_seen);
        rep.rms_c    = channel_rms_micro(square_total[2], triples_seen);
        pending_reports.push_back(rep);
        foreach (square_total[i])
            square_total[i] = '0;
        triples_seen = '0;
        window_age   = '0;
        window_began = ms_now;
    endfunction

    // A sample value that hits the extremes now and then.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transaction and wait until the block takes it.
    task automatic send_item(input logic m, input logic signed [15:0] a,
                             input logic signed [15:0] b, input logic signed [15:0] c);
        if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        mode     <= m;
        sample_a <= a;
        sample_b <= b;
        sample_c <= c;
        do
            @(posedge clk);
        while (full);
        predict_item(m, a, b, c);
        @(negedge clk);
    endtask

    task automatic send_triple(input logic signed [15:0] a, input logic signed [15:0] b,
                               input logic signed [15:0] c);
        send_item(tcwr_pkg::MODE_SAMPLE, a, b, c);
    endtask

    // Tick transactions carry random sample fields, which the block must ignore.
    task automatic send_tick();
        send_item(tcwr_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_random_triple();
        send_triple(pick_sample(), pick_sample(), pick_sample());
    endtask

    // Stop offering, wait for every predicted report, then let the back end go quiet.
    task automatic drain_and_settle();
        push <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic cfg_write(input logic [tcwr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcwr_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == tcwr_pkg::REG_WINDOW_MS)
            window_len = value[15:0];
        else if (idx == tcwr_pkg::REG_GAIN_MICRO)
            gain_setting = value[19:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Reset values of both registers: one full default window.
    task automatic test_reset_defaults();
        send_triple(16'sh7FFF, 16'sh8000, 16'sh0001);
        send_triple(16'shFFFF, 16'sh0000, 16'sh8000);
        send_triple(16'sd12345, -16'sd20000, 16'sd7);
        repeat (1000) send_tick();
        drain_and_settle();
    endtask

    // Extreme samples, maximum and zero gain, and a window with no samples.
    task automatic test_field_extremes();
        cfg_write(tcwr_pkg::REG_WINDOW_MS, 20'd2);
        cfg_write(tcwr_pkg::REG_GAIN_MICRO, tcwr_pkg::CFG_W'(GAIN_MAX));
        send_triple(16'sh8000, 16'sh8000, 16'sh8000);
        send_triple(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_triple(16'sh0000, 16'shFFFF, 16'sh0001);
        send_tick();
        send_triple(16'sh8000, 16'sh7FFF, 16'sh0000);
        send_tick();
        send_tick();
        send_tick();
        drain_and_settle();
        cfg_write(tcwr_pkg::REG_GAIN_MICRO, '0);
        send_triple(16'sh8000, 16'sh1234, 16'shFFFF);
        send_tick();
        send_tick();
        drain_and_settle();
    endtask

    // A window length of zero closes a window on every tick.
    task automatic test_zero_window();
        cfg_write(tcwr_pkg::REG_WINDOW_MS, '0);
        cfg_write(tcwr_pkg::REG_GAIN_MICRO, tcwr_pkg::CFG_W'(tcwr_pkg::GAIN_RESET));
        send_tick();
        send_random_triple();
        send_tick();
        send_tick();
        drain_and_settle();
    endtask

    // Writes to unused indexes change nothing; a shorter window closes on the next tick.
    task automatic test_shortened_window();
        cfg_write(tcwr_pkg::REG_WINDOW_MS, 20'hFFFF);
        cfg_write(tcwr_pkg::REG_GAIN_MICRO, tcwr_pkg::CFG_W'($urandom_range(1, 20'hFFFFF)));
        cfg_write(REG_SPARE_LO, '1);
        cfg_write(REG_SPARE_HI, tcwr_pkg::CFG_W'($urandom));
        repeat (5)
        begin
            send_random_triple();
            send_tick();
        end
        send_tick();
        send_tick();
        send_tick();
        drain_and_settle();
        cfg_write(tcwr_pkg::REG_WINDOW_MS, 20'd3);
        send_tick();
        send_random_triple();
        repeat (3) send_tick();
        drain_and_settle();
    endtask

    // Receiver holds off long enough for the window queue to fill and stall the input.
    task automatic test_back_pressure();
        cfg_write(tcwr_pkg::REG_WINDOW_MS, 20'd1);
        cfg_write(tcwr_pkg::REG_GAIN_MICRO, tcwr_pkg::CFG_W'(GAIN_MAX));
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (8)
        begin
            send_random_triple();
            send_tick();
        end
        drain_and_settle();
    endtask

    // Random traffic over several register settings.
    task automatic test_random_traffic();
        logic [19:0] gain_pick;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 2)
                gain_pick = '0;
            else if (p == 3)
                gain_pick = GAIN_MAX;
            else
                gain_pick = 20'($urandom_range(0, 20'hFFFFF));
            cfg_write(tcwr_pkg::REG_WINDOW_MS,
                      (p == 1) ? 20'd1 : tcwr_pkg::CFG_W'($urandom_range(1, 12)));
            cfg_write(tcwr_pkg::REG_GAIN_MICRO, tcwr_pkg::CFG_W'(gain_pick));
            // The first phase runs without any idling on either side.
            idle_pct = (p == 0) ? 0 : 14;
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 30)
                    send_tick();
                else
                    send_random_triple();
            end
            drain_and_settle();
        end
        idle_pct = 14;
    endtask

    // Result side: random pop with an occasional long hold-off.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Check each popped report against the oldest prediction.
    always @(posedge clk)
    begin
        window_report_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report popped with none predicted: start %0d count %0d",
                       window_start_ms, sample_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("window_start_ms", 64'(want.start_ms), 64'(window_start_ms));
                compare_field("sample_count", 64'(want.count), 64'(sample_count));
                compare_field("rms_a", 64'(want.rms_a), 64'(rms_a));
                compare_field("rms_b", 64'(want.rms_b), 64'(rms_b));
                compare_field("rms_c", 64'(want.rms_c), 64'(rms_c));
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_three_channel_windowed_rms NOT OK");
            $finish;
        end
    end

    initial
    begin
        foreach (square_total[i])
            square_total[i] = '0;
        triples_seen = '0;
        window_age   = '0;
        ms_now       = '0;
        window_began = '0;
        window_len   = tcwr_pkg::WINDOW_RESET;
        gain_setting = tcwr_pkg::GAIN_RESET;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_zero_window();
        test_shortened_window();
        test_back_pressure();
        test_random_traffic();

        drain_and_settle();
        if (pending_reports.size() != 0)
        begin
            $error("%0d predicted reports never arrived", pending_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_three_channel_windowed_rms OK");
        else
            $display("tb_three_channel_windowed_rms NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcwr_pkg.sv
rtl/tcwr_front.sv
rtl/tcwr_jobq.sv
rtl/tcwr_back.sv
rtl/three_channel_windowed_rms.sv
sim/tb_three_channel_windowed_rms.sv
